### rtl/core/nec_pkg.sv
// Package for the NFA epsilon-closure core: field widths, reset values and the
// control struct passed from the sequencer to the closure walk unit.
// No dependencies.
package nec_pkg;

    localparam int STATE_W       = 5;   // width of a state number field
    localparam int CFG_W         = 6;   // width of the num_states register
    localparam int MASK_W        = 32;  // width of a closure mask
    localparam int FIELD_NODES   = 32;  // states reachable by a 5-bit field
    localparam int MAX_NODES_DEF = 32;

    localparam logic [CFG_W-1:0] NUM_STATES_RST = CFG_W'(32);

    // Per-cycle command to the closure walk unit
    typedef struct packed {
        logic start;  // seed the walk with a single state
        logic step;   // expand the lowest pending state
    } t_walk_ctl;

endpackage

### rtl/core/nec_edge_matrix.sv
// Epsilon adjacency bit matrix held in flip-flops: single-bit set per edge,
// one-hot row read for the walk, whole-matrix clear.
// Depends on nec_pkg.
module nec_edge_matrix #(
    parameter int ROWS = nec_pkg::MAX_NODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [nec_pkg::STATE_W-1:0] i_wr_from,
    input  logic [nec_pkg::STATE_W-1:0] i_wr_to,
    input  logic                       i_clear,
    input  logic [ROWS-1:0]            i_rd_sel,
    output logic [ROWS-1:0]            o_rd_row
);
    import nec_pkg::*;

    logic [ROWS-1:0] r_row [ROWS];
    logic [ROWS-1:0] w_row_hit;
    logic [ROWS-1:0] w_col_hit;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_row_hit[r] = i_wr_en && (i_wr_from == STATE_W'(r));
            w_col_hit[r] = (i_wr_to == STATE_W'(r));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_row[r] <= '0;
            end
        end else if (i_clear) begin
            for (int r = 0; r < ROWS; r++) begin
                r_row[r] <= '0;
            end
        end else begin
            for (int r = 0; r < ROWS; r++) begin
                if (w_row_hit[r]) begin
                    r_row[r] <= r_row[r] | w_col_hit;
                end
            end
        end
    end

    // AND-OR select of the row named by the one-hot pick
    always_comb begin
        o_rd_row = '0;
        for (int r = 0; r < ROWS; r++) begin
            o_rd_row = o_rd_row | (i_rd_sel[r] ? r_row[r] : '0);
        end
    end

endmodule

### rtl/core/nec_closure_unit.sv
// Closure walk unit: holds the reached and expanded sets, isolates the lowest
// pending state each cycle and folds in that state's adjacency row.
// Depends on nec_pkg.
module nec_closure_unit #(
    parameter int WIDTH = nec_pkg::MAX_NODES_DEF
) (
    input  logic                        i_clk,
    input  nec_pkg::t_walk_ctl          i_ctl,
    input  logic [nec_pkg::STATE_W-1:0] i_seed,
    input  logic [WIDTH-1:0]            i_lim,
    input  logic [WIDTH-1:0]            i_row,
    output logic [WIDTH-1:0]            o_pick,
    output logic                        o_done,
    output logic [WIDTH-1:0]            o_work
);
    import nec_pkg::*;

    logic [WIDTH-1:0] r_work;
    logic [WIDTH-1:0] r_expanded;
    logic [WIDTH-1:0] n_work;
    logic [WIDTH-1:0] n_expanded;
    logic [WIDTH-1:0] w_pending;
    logic [WIDTH-1:0] w_seed_bit;

    always_comb begin
        for (int j = 0; j < WIDTH; j++) begin
            w_seed_bit[j] = (i_seed == STATE_W'(j));
        end
    end

    assign w_pending = r_work & ~r_expanded & i_lim;
    // lowest set bit of the pending set
    assign o_pick    = w_pending & (~w_pending + WIDTH'(1));
    assign o_done    = (w_pending == '0);
    assign o_work    = r_work;

    always_comb begin
        n_work     = r_work;
        n_expanded = r_expanded;
        if (i_ctl.start) begin
            n_work     = w_seed_bit;
            n_expanded = '0;
        end else if (i_ctl.step) begin
            n_work     = r_work | (i_row & i_lim);
            n_expanded = r_expanded | o_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_expanded <= n_expanded;
    end

endmodule

### rtl/core/nfa_epsilon_closure_core.sv
// NFA epsilon-closure core: stores epsilon edges, then emits one closure per state.
// Edges are taken one per cycle. The edge marked last starts the walk: each state
// is seeded, walked until none is pending, then held at the output while the
// sink stalls; the shared closure unit expands one state per cycle.
// Synchronous active-low reset clears the edge matrix and sets num_states to 32.
// Depends on nec_pkg, nec_edge_matrix and nec_closure_unit.
module nfa_epsilon_closure_core #(
    parameter int MAX_NODES = nec_pkg::MAX_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nec_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [nec_pkg::STATE_W-1:0]  i_from_state,
    input  logic [nec_pkg::STATE_W-1:0]  i_to_state,
    input  logic                         i_is_epsilon,
    input  logic                         i_last_edge,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [nec_pkg::STATE_W-1:0]  o_state_index,
    output logic [nec_pkg::MASK_W-1:0]   o_closure_mask,
    output logic                         o_last_result
);
    import nec_pkg::*;

    localparam int NR = (MAX_NODES < FIELD_NODES) ? MAX_NODES : FIELD_NODES;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_INIT = 4'b0010,
        ST_WALK = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_num_states;
    logic [STATE_W-1:0]    r_idx, n_idx;
    logic [STATE_W-1:0]    r_out_index, n_out_index;
    logic [MASK_W-1:0]     r_out_mask, n_out_mask;
    logic                  r_out_last, n_out_last;

    logic [CFG_W-1:0]      w_nodes;
    logic [NR-1:0]         w_lim;
    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_wr_en;
    logic                  w_clear;
    t_walk_ctl             w_ctl;
    logic [NR-1:0]         w_pick;
    logic [NR-1:0]         w_row;
    logic                  w_done;
    logic [NR-1:0]         w_work;

    assign w_nodes = (r_num_states > CFG_W'(NR)) ? CFG_W'(NR) : r_num_states;

    always_comb begin
        for (int j = 0; j < NR; j++) begin
            w_lim[j] = (w_nodes > CFG_W'(j));
        end
    end

    assign o_ready    = (r_state == ST_LOAD);
    assign o_valid    = (r_state == ST_EMIT);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    assign w_wr_en = w_in_xfer && i_is_epsilon
                     && (CFG_W'(i_from_state) < w_nodes)
                     && (CFG_W'(i_to_state) < w_nodes);
    // drop the edge set once the final closure has gone, or at once if no states
    assign w_clear = (w_in_xfer && i_last_edge && (w_nodes == '0))
                     || (w_out_xfer && r_out_last);

    nec_edge_matrix #(
        .ROWS (NR)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_from (i_from_state),
        .i_wr_to   (i_to_state),
        .i_clear   (w_clear),
        .i_rd_sel  (w_pick),
        .o_rd_row  (w_row)
    );

    nec_closure_unit #(
        .WIDTH (NR)
    ) u_walk (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_seed (r_idx),
        .i_lim  (w_lim),
        .i_row  (w_row),
        .o_pick (w_pick),
        .o_done (w_done),
        .o_work (w_work)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_index = r_out_index;
        n_out_mask  = r_out_mask;
        n_out_last  = r_out_last;
        w_ctl       = '0;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer && i_last_edge && (w_nodes != '0)) begin
                    n_idx   = '0;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                w_ctl.start = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                if (w_done) begin
                    n_out_index = r_idx;
                    n_out_mask  = MASK_W'(w_work & w_lim);
                    n_out_last  = ((CFG_W'(r_idx) + CFG_W'(1)) == w_nodes);
                    n_state     = ST_EMIT;
                end else begin
                    w_ctl.step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    if (r_out_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + STATE_W'(1);
                        n_state = ST_INIT;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_idx        <= '0;
            r_num_states <= NUM_STATES_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_num_states <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_mask  <= n_out_mask;
        r_out_last  <= n_out_last;
    end

    assign o_state_index  = r_out_index;
    assign o_closure_mask = r_out_mask;
    assign o_last_result  = r_out_last;

    // The input side is never open while a closure is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a closure is pending");

    // Every closure holds its own state
    a_self_in_closure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_closure_mask[o_state_index])
        else $error("closure misses its own state");

    // No bits at or above the number of states in use
    a_mask_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_closure_mask & ~MASK_W'(w_lim)) == '0))
        else $error("closure bit beyond states in use");

    // Final closure transfer reopens the input side
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_last_result) |=> o_ready)
        else $error("input not reopened after final closure");

    // Non-final transfer moves on to the next state
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !o_last_result) |=> (r_idx == $past(o_state_index) + STATE_W'(1)))
        else $error("state index did not advance");

endmodule
